// ===== hdl/mbfbs_pkg.sv =====
package mbfbs_pkg;

    localparam int FILTER_COUNT    = 16;
    localparam int MAX_FILTER_BITS = 65536;

    // field widths
    localparam int OP_W   = 1;
    localparam int FIDX_W = 4;
    localparam int HASH_W = 63;
    localparam int CFG_W  = 17;

    // largest modulus that the config field can express after clamping
    localparam int CFG_MAX   = (1 << CFG_W) - 1;
    localparam int MOD_MIN   = 8;
    localparam int MOD_MAX   = (MAX_FILTER_BITS > CFG_MAX) ? CFG_MAX : MAX_FILTER_BITS;

    // bit store geometry, one byte per entry
    localparam int SLOT_BYTES  = MAX_FILTER_BITS / 8;
    localparam int STORE_BYTES = FILTER_COUNT * SLOT_BYTES;
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int BITNUM_W    = $clog2(MAX_FILTER_BITS);

    // serial remainder step counter width
    localparam int CNT_W = $clog2(HASH_W);

    // APB
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic REG_IDX_BITS_PER_FILTER = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ADD    = 1'b0,
        OP_LOOKUP = 1'b1
    } t_op;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [FIDX_W-1:0] filter_index;
        logic [HASH_W-1:0] hash_value;
        logic              last_hash;
    } t_in_beat;

    typedef struct packed {
        logic was_lookup;
        logic found;
    } t_out_beat;

    typedef struct packed {
        logic              valid;
        logic              lookup;
        logic              in_range;
        logic [ADDR_W-1:0] addr;
        logic [2:0]        bit_sel;
    } t_store_req;

    typedef struct packed {
        logic done;
        logic hit;
        logic ready;
    } t_store_rsp;

endpackage

// ===== hdl/multi_bloom_filter_bit_store.sv =====
// Beats are taken one at a time: a new beat is accepted only after the last one has
//   passed the bit-serial remainder (63 steps) and the store read-modify-write; after a
//   group's last beat, also only once the output register is free to take its result.
// Reset: synchronous, active low. Afterward the bit store is zeroed by a sweep over
//   all 131072 bytes (one byte per cycle) during which no beat is accepted;
//   bits_per_filter resets to 65536 and register writes are taken at any time.
module multi_bloom_filter_bit_store (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  mbfbs_pkg::t_in_beat               i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output mbfbs_pkg::t_out_beat              o_out_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [mbfbs_pkg::PADDR_W-1:0]     paddr,
    input  logic [mbfbs_pkg::PDATA_W-1:0]     pwdata,
    output logic [mbfbs_pkg::PDATA_W-1:0]     prdata,
    output logic                              pready
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_REQ  = 5'b00100,
        S_WAIT = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state                          r_state, n_state;
    logic [mbfbs_pkg::CFG_W-1:0]     r_cfg_bits;
    logic [mbfbs_pkg::CFG_W-1:0]     eff_mod;
    logic                            r_lookup;
    logic [mbfbs_pkg::FIDX_W-1:0]    r_fidx;
    logic                            r_last;
    logic                            r_all_set;
    logic                            r_found;
    logic                            r_out_valid;
    mbfbs_pkg::t_out_beat            r_out;

    logic                            accept;
    logic                            cfg_write;
    logic                            out_free;
    logic                            rem_done;
    logic [mbfbs_pkg::CFG_W-1:0]     rem;
    logic [mbfbs_pkg::BITNUM_W-1:0]  bitnum;
    logic                            flag_new;
    mbfbs_pkg::t_store_req           store_req;
    mbfbs_pkg::t_store_rsp           store_rsp;

    // config port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite
                       && (paddr[2] == mbfbs_pkg::REG_IDX_BITS_PER_FILTER);
    assign prdata    = (paddr[2] == mbfbs_pkg::REG_IDX_BITS_PER_FILTER)
                       ? mbfbs_pkg::PDATA_W'(r_cfg_bits) : '0;

    always_comb begin
        if (r_cfg_bits < mbfbs_pkg::CFG_W'(mbfbs_pkg::MOD_MIN)) begin
            eff_mod = mbfbs_pkg::CFG_W'(mbfbs_pkg::MOD_MIN);
        end else if (r_cfg_bits > mbfbs_pkg::CFG_W'(mbfbs_pkg::MOD_MAX)) begin
            eff_mod = mbfbs_pkg::CFG_W'(mbfbs_pkg::MOD_MAX);
        end else begin
            eff_mod = r_cfg_bits;
        end
    end

    assign accept     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || !store_rsp.ready;
    assign out_free   = !r_out_valid || !i_out_stall;

    mbfbs_rem u_rem (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (accept),
        .i_dividend  (i_in_data.hash_value),
        .i_modulus   (eff_mod),
        .o_done      (rem_done),
        .o_remainder (rem)
    );

    assign bitnum = mbfbs_pkg::BITNUM_W'(rem);

    always_comb begin
        store_req.valid    = (r_state == S_REQ);
        store_req.lookup   = r_lookup;
        store_req.in_range = (32'(r_fidx) < 32'(mbfbs_pkg::FILTER_COUNT));
        store_req.addr     = mbfbs_pkg::ADDR_W'(32'(r_fidx) * 32'(mbfbs_pkg::SLOT_BYTES)
                                                + 32'(bitnum >> 3));
        store_req.bit_sel  = bitnum[2:0];
    end

    mbfbs_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (store_req),
        .o_rsp   (store_rsp)
    );

    // adds leave the running flag alone
    assign flag_new = r_all_set && (!r_lookup || store_rsp.hit);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (accept) n_state = S_DIV;
            S_DIV:  if (rem_done) n_state = S_REQ;
            S_REQ:  n_state = S_WAIT;
            S_WAIT: begin
                if (store_rsp.done) begin
                    n_state = r_last ? S_OUT : S_IDLE;
                end
            end
            S_OUT:  if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg_bits  <= mbfbs_pkg::CFG_W'(65536);
            r_all_set   <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cfg_write) begin
                r_cfg_bits <= pwdata[mbfbs_pkg::CFG_W-1:0];
            end
            if (r_state == S_WAIT && store_rsp.done) begin
                r_all_set <= r_last ? 1'b1 : flag_new;
            end
            if (r_state == S_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_lookup <= (i_in_data.operation == mbfbs_pkg::OP_LOOKUP);
            r_fidx   <= i_in_data.filter_index;
            r_last   <= i_in_data.last_hash;
        end
        if (r_state == S_WAIT && store_rsp.done) begin
            r_found <= r_lookup ? flag_new : 1'b1;
        end
        if (r_state == S_OUT && out_free) begin
            r_out.was_lookup <= r_lookup;
            r_out.found      <= r_found;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

// ===== hdl/mbfbs_rem.sv =====
module mbfbs_rem (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic [mbfbs_pkg::HASH_W-1:0]      i_dividend,
    input  logic [mbfbs_pkg::CFG_W-1:0]       i_modulus,
    output logic                              o_done,
    output logic [mbfbs_pkg::CFG_W-1:0]       o_remainder
);

    logic [mbfbs_pkg::HASH_W-1:0] r_dvd;
    logic [mbfbs_pkg::CFG_W-1:0]  r_mod;
    logic [mbfbs_pkg::CFG_W-1:0]  r_rem, n_rem;
    logic [mbfbs_pkg::CNT_W-1:0]  r_cnt;
    logic                         r_busy;
    logic                         r_done;
    logic [mbfbs_pkg::CFG_W:0]    trial;

    // restoring remainder, one dividend bit per cycle, MSB first
    always_comb begin
        trial = {r_rem, r_dvd[mbfbs_pkg::HASH_W-1]};
        if (trial >= {1'b0, r_mod}) begin
            n_rem = mbfbs_pkg::CFG_W'(trial - {1'b0, r_mod});
        end else begin
            n_rem = mbfbs_pkg::CFG_W'(trial);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= mbfbs_pkg::CNT_W'(mbfbs_pkg::HASH_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_mod <= i_modulus;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[mbfbs_pkg::HASH_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_remainder = r_rem;

endmodule

// ===== hdl/mbfbs_store.sv =====
module mbfbs_store (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mbfbs_pkg::t_store_req   i_req,
    output mbfbs_pkg::t_store_rsp   o_rsp
);

    logic [7:0] mem [mbfbs_pkg::STORE_BYTES];

    logic                          r_clearing;
    logic [mbfbs_pkg::ADDR_W-1:0]  r_clr_addr;
    logic                          r_busy;
    logic                          r_done;
    logic                          r_hit;
    logic [7:0]                    r_rdata;
    logic [mbfbs_pkg::ADDR_W-1:0]  r_addr;
    logic                          r_lookup;
    logic                          r_in_range;
    logic [2:0]                    r_bit;
    logic [7:0]                    mask;

    assign mask = 8'(1) << r_bit;

    // clearing sweep after reset, then a read, with the modify/write in the cycle after it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_busy     <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == mbfbs_pkg::ADDR_W'(mbfbs_pkg::STORE_BYTES - 1)) begin
                    r_clearing <= 1'b0;
                end
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else if (i_req.valid) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && !r_busy) begin
            r_rdata    <= mem[i_req.addr];
            r_addr     <= i_req.addr;
            r_lookup   <= i_req.lookup;
            r_in_range <= i_req.in_range;
            r_bit      <= i_req.bit_sel;
        end
        if (r_busy) begin
            r_hit <= r_in_range && ((r_rdata & mask) != 8'd0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clearing) begin
            mem[r_clr_addr] <= 8'd0;
        end else if (r_busy && !r_lookup && r_in_range) begin
            mem[r_addr] <= r_rdata | mask;
        end
    end

    assign o_rsp.done  = r_done;
    assign o_rsp.hit   = r_hit;
    assign o_rsp.ready = !r_clearing;

endmodule
